@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// All checks are sampled on aclk and are off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/itd_pkg.sv @@
// ----------------------------------------------------------------------------
// itd_pkg
// Shared types, constants and the shift-add-3 step for the integer-to-decimal
// text converter.
// ----------------------------------------------------------------------------
package itd_pkg;

    localparam int VALUE_W      = 32;
    localparam int CHAR_W       = 8;
    localparam int DIGITS       = 10;
    localparam int BCD_W        = 4 * DIGITS;
    localparam int IDX_W        = 4;
    localparam int STEPS_STAGE  = 8;
    localparam int DAB_STAGES   = VALUE_W / STEPS_STAGE;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    // Conversion word in flight: sign, BCD accumulator, binary bits left
    typedef struct packed {
        logic               neg;
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } dab_t;

    // One double-dabble step: correct every digit of five or more, then shift
    function automatic dab_t dabble_step(input dab_t d);
        dab_t       r;
        logic [3:0] dig;
        r = d;
        for (int i = 0; i < DIGITS; i++) begin
            dig = r.bcd[4*i +: 4];
            if (dig >= 4'd5) begin
                r.bcd[4*i +: 4] = dig + 4'd3;
            end
        end
        {r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
        return r;
    endfunction

    // Index of the highest nonzero digit; zero for a value of zero
    function automatic logic [IDX_W-1:0] top_digit(input logic [BCD_W-1:0] bcd);
        logic [IDX_W-1:0] top;
        top = '0;
        for (int i = 1; i < DIGITS; i++) begin
            if (bcd[4*i +: 4] != 4'd0) begin
                top = IDX_W'(i);
            end
        end
        return top;
    endfunction

endpackage

@@ rtl/itd_sign.sv @@
// ----------------------------------------------------------------------------
// itd_sign
// First pipeline stage: split the input into sign and unsigned magnitude.
// ----------------------------------------------------------------------------
module itd_sign (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [itd_pkg::VALUE_W-1:0]  in_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output itd_pkg::dab_t                       out_data
);
    import itd_pkg::*;

    logic valid_reg;
    dab_t data_reg;
    dab_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Form the magnitude as unsigned so the most negative value stays exact
    always_comb begin
        data_next.neg = in_value[VALUE_W-1];
        data_next.bcd = '0;
        data_next.bin = in_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_value))
                                            : VALUE_W'(in_value);
    end

    // Hold valid until the next stage takes the word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/itd_dabble.sv @@
// ----------------------------------------------------------------------------
// itd_dabble
// One binary-to-BCD pipeline stage: eight shift-add-3 steps, then a register.
// ----------------------------------------------------------------------------
module itd_dabble (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  itd_pkg::dab_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output itd_pkg::dab_t out_data
);
    import itd_pkg::*;

    logic valid_reg;
    dab_t data_reg;
    dab_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Run this stage's share of the conversion steps
    always_comb begin
        data_next = in_data;
        for (int s = 0; s < STEPS_STAGE; s++) begin
            data_next = dabble_step(data_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/itd_serial.sv @@
// ----------------------------------------------------------------------------
// itd_serial
// Output stage: emit the sign and the significant digits one transfer at a
// time, most significant first, flagging the final character.
// ----------------------------------------------------------------------------
module itd_serial (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  itd_pkg::dab_t                in_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [itd_pkg::CHAR_W-1:0]   m_character,
    output logic                         m_last
);
    import itd_pkg::*;

    logic                 busy_reg;
    logic                 minus_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [BCD_W-1:0]     bcd_reg;
    logic [3:0]           digit;
    logic                 done;

    // Current character comes straight from held state, stable under stall
    assign digit       = bcd_reg[4*idx_reg +: 4];
    assign m_valid     = busy_reg;
    assign m_last      = !minus_reg && (idx_reg == '0);
    assign m_character = minus_reg ? ASCII_MINUS : (ASCII_ZERO + CHAR_W'(digit));

    // Load the next number as soon as the final character transfers
    assign done     = busy_reg && m_ready && m_last;
    assign in_ready = !busy_reg || done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (in_ready) begin
            busy_reg <= in_valid;
        end
    end

    // Advance through the sign, then the digits down to the units
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            bcd_reg   <= in_data.bcd;
            minus_reg <= in_data.neg;
            idx_reg   <= top_digit(in_data.bcd);
        end else if (busy_reg && m_ready) begin
            if (minus_reg) begin
                minus_reg <= 1'b0;
            end else if (idx_reg != '0) begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
        end
    end

endmodule

@@ rtl/signed_int_to_decimal_ascii_top.sv @@
// Path: a number's first character is offered once it has passed the sign stage
// register, four conversion stage registers, then the output stage register.
// Throughput: one character per cycle while m_ready is high, 1 to 11 characters per
// number; the output stage serializer sets the rate, and a new number loads on the last transfer.
// Reset: synchronous active-low aresetn clears all valid flags.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a 32-bit two's complement integer to its decimal ASCII text.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_int_to_decimal_ascii_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [itd_pkg::VALUE_W-1:0]  s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [itd_pkg::CHAR_W-1:0]          m_character,
    output logic                                m_last
);
    import itd_pkg::*;

    logic stg_valid [DAB_STAGES+1];
    logic stg_ready [DAB_STAGES+1];
    dab_t stg_data  [DAB_STAGES+1];

    // Sign and magnitude
    itd_sign u_sign (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    // Binary to BCD, eight bits per stage
    for (genvar g = 0; g < DAB_STAGES; g++) begin : g_dab
        itd_dabble u_dabble (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_data   (stg_data[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_data  (stg_data[g+1])
        );
    end

    // Character serializer
    itd_serial u_serial (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (stg_valid[DAB_STAGES]),
        .in_ready    (stg_ready[DAB_STAGES]),
        .in_data     (stg_data[DAB_STAGES]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    // Classify the offered character
    logic char_is_minus;
    logic char_is_digit;
    logic char_is_lead;
    logic minus_xfer;

    assign char_is_minus = (m_character == ASCII_MINUS);
    assign char_is_digit = (m_character >= ASCII_ZERO) && (m_character <= ASCII_ZERO + 8'd9);
    assign char_is_lead  = char_is_digit && (m_character != ASCII_ZERO);
    assign minus_xfer    = m_valid && m_ready && char_is_minus;

    // Every offered character is a minus sign or a decimal digit
    `ASSERT_IMP(a_char_range, m_valid, char_is_minus || char_is_digit, "character out of range")

    // A minus sign never ends a number
    `ASSERT_IMP(a_minus_not_last, m_valid && char_is_minus, !m_last, "minus flagged last")

    // The digit after a minus sign follows at once and is never a leading zero
    `ASSERT_NXT(a_minus_then_digit, minus_xfer, m_valid && char_is_lead, "bad digit after minus")

endmodule

@@ bench/signed_int_to_decimal_ascii_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top_test
// Self-checking bench for the integer-to-decimal text converter. Numbers are
// fed through the input channel, and a scoreboard spells out the decimal
// text of each accepted number. Every character transfer on the output
// channel is compared with the oldest spelled character. Both channels idle
// at random, and one long receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top_test;
    import itd_pkg::*;

    // One character of expected text
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    // Spells each accepted number and checks the characters that come out
    class text_scoreboard;
        text_char_t spelled_q[$];
        int         mismatches;
        int         chars_checked;

        function new();
            mismatches    = 0;
            chars_checked = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        // Spell the decimal text of an accepted number, most significant first
        function void note_value(input logic signed [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] mag;
            int                 digit_buf [DIGITS];
            int                 n;
            text_char_t         c;
            // magnitude as unsigned, so the most negative value stays exact
            mag = value;
            if (value[VALUE_W-1]) begin
                mag = ~mag + 1;
            end
            n = 0;
            do begin
                digit_buf[n] = int'(mag % 10);
                mag          = mag / 10;
                n++;
            end while (mag != 0);
            if (value[VALUE_W-1]) begin
                c.code = ASCII_MINUS;
                c.last = 1'b0;
                spelled_q.push_back(c);
            end
            for (int i = n - 1; i >= 0; i--) begin
                c.code = ASCII_ZERO + CHAR_W'(digit_buf[i]);
                c.last = (i == 0);
                spelled_q.push_back(c);
            end
        endfunction

        // Compare one character transfer with the oldest spelled character
        task check_char(input logic [CHAR_W-1:0] code, input logic last);
            text_char_t want;
            chars_checked++;
            if (spelled_q.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h last=%0b", code, last));
            end else begin
                want = spelled_q.pop_front();
                if (code !== want.code) begin
                    report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                              code, want.code));
                end
                if (last !== want.last) begin
                    report_mismatch($sformatf("last %0b on character 0x%02h, expected %0b",
                                              last, want.code, want.last));
                end
            end
        endtask

        function int pending();
            return spelled_q.size();
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [VALUE_W-1:0]  s_value;
    logic                       m_valid;
    logic                       m_ready;
    logic [CHAR_W-1:0]          m_character;
    logic                       m_last;

    text_scoreboard sb;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             ready_hold_left;
    int             numbers_sent;
    int             negatives_sent;
    int             longest_sent;
    int             input_stall_cycles;

    signed_int_to_decimal_ascii_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Check every character transfer; count cycles the input is held off
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_char(m_character, m_last);
            end
            if (s_valid && !s_ready) begin
                input_stall_cycles++;
            end
        end
    end

    // Receiver: random ready, or a counted hold-off when one is requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (ready_hold_left > 0) begin
                m_ready <= 1'b0;
                ready_hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offer one number, idling first at random, and note it on transfer
    task send_value(input logic signed [VALUE_W-1:0] value);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_value(value);
        numbers_sent++;
        if (value < 0) begin
            negatives_sent++;
        end
        if (value == -32'sd2147483648) begin
            longest_sent++;
        end
    endtask

    // Random number: mostly a chosen digit count and sign, some raw bit
    // patterns and some extremes
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int          sel;
        int          ndig;
        longint      lo;
        longint      hi;
        longint      mag;
        logic        neg;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            return $urandom;
        end
        if (sel < 18) begin
            case ($urandom_range(0, 3))
                0: return 32'sd0;
                1: return 32'sd2147483647;
                2: return -32'sd2147483648;
                default: return -32'sd1;
            endcase
        end
        ndig = $urandom_range(1, DIGITS);
        neg  = $urandom_range(0, 1);
        // powers of ten in 64 bits, so ten digits reach the full range
        lo   = (ndig == 1) ? 0 : longint'(10) ** (ndig - 1);
        hi   = longint'(10) ** ndig - 1;
        if (hi > 64'd2147483648) begin
            hi = 64'd2147483648;
        end
        mag = $urandom_range(int'(hi), int'(lo));
        // keep the magnitude non-negative after the 32-bit range pick
        mag = mag & 64'hFFFF_FFFF;
        if (!neg && mag > 64'd2147483647) begin
            mag = 64'd2147483647;
        end
        return neg ? -VALUE_W'(mag) : VALUE_W'(mag);
    endfunction

    // Directed numbers: zero, sign edges, one to three, nine and ten digits, inner zeros
    logic signed [VALUE_W-1:0] directed_values [] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
        32'sd100, 32'sd1000000000, -32'sd1000000000, 32'sd999999999,
        -32'sd999999999, 32'sd1999999999, 32'sd2000000001, 32'sd123456789,
        -32'sd1234567890, 32'sd2147483647, -32'sd2147483647, -32'sd2147483648,
        32'sd1000000001, -32'sd2147483640
    };

    // Generous cap on the whole run
    initial begin
        #4000000;
        $display("Timeout: %0d characters still expected", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        sb                 = new();
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_value            = '0;
        send_idle_pct      = 32;
        recv_idle_pct      = 86;
        ready_hold_left    = 0;
        numbers_sent       = 0;
        negatives_sent     = 0;
        longest_sent       = 0;
        input_stall_cycles = 0;

        // Hold reset low, then release it
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, then random with a slow receiver
        foreach (directed_values[i]) begin
            send_value(directed_values[i]);
        end
        repeat (103) send_value(pick_value());

        // Slow sender, quick receiver
        send_idle_pct = 86;
        recv_idle_pct = 32;
        repeat (103) send_value(pick_value());

        // No idling; start with a long receiver hold-off to back up the input
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        ready_hold_left = 400;
        repeat (103) send_value(pick_value());

        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain, then watch for stray characters
        while (sb.pending() > 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        $display("Converted %0d numbers (%0d negative, %0d most negative), %0d characters",
                 numbers_sent, negatives_sent, longest_sent, sb.chars_checked);
        $display("Input held off for %0d cycles; %0d mismatches",
                 input_stall_cycles, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/itd_pkg.sv
rtl/itd_sign.sv
rtl/itd_dabble.sv
rtl/itd_serial.sv
rtl/signed_int_to_decimal_ascii_top.sv
bench/signed_int_to_decimal_ascii_top_test.sv
